// ===== sv/glyph_outline_shadow_compositor_top_macros.svh =====
// Assertion helpers for the compositor top module.
`ifndef GLYPH_OUTLINE_SHADOW_COMPOSITOR_TOP_MACROS_SVH
`define GLYPH_OUTLINE_SHADOW_COMPOSITOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GOSC_ASSERT_SAME(label, clk_s, rst_s, pre, post) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
    else $error("compositor assertion failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define GOSC_ASSERT_NEXT(label, clk_s, rst_s, pre, post) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
    else $error("compositor assertion failed (next cycle)");

`endif

// ===== sv/gosc_pkg.sv =====
`default_nettype none

package gosc_pkg;

  localparam int MAX_GLYPH_WIDTH = 256;
  localparam int SCREEN_WIDTH    = 1280;
  localparam int SCREEN_HEIGHT   = 720;
  localparam int HEIGHT_LIMIT    = 256;

  // One line store entry per padded grid column.
  localparam int LINE_DEPTH = MAX_GLYPH_WIDTH + 2;
  localparam int COL_W      = $clog2(LINE_DEPTH);
  localparam int ROW_W      = $clog2(HEIGHT_LIMIT + 2);

  localparam int SIZE_W  = 9;
  localparam int POS_W   = 12;
  localparam int CMP_W   = (COL_W > SIZE_W) ? COL_W : SIZE_W;
  localparam int SUM_W   = ((COL_W > POS_W) ? COL_W : POS_W) + 2;
  localparam int SX_W    = 11;
  localparam int SY_W    = 10;
  localparam int COLOR_W = 24;
  localparam int OUT_DATA_W = 48;

  localparam logic [COLOR_W-1:0] STROKE_RGB  = 24'h101E2D;
  localparam logic [COLOR_W-1:0] SHADOW_RGB  = 24'h160E08;
  localparam logic [7:0]         WHITE_LEVEL = 8'd245;

  typedef enum logic [1:0] {
    CFG_GLYPH_WIDTH  = 2'd0,
    CFG_GLYPH_HEIGHT = 2'd1,
    CFG_DEST_X       = 2'd2,
    CFG_DEST_Y       = 2'd3
  } cfg_reg_t;

  // mask[0] is this row's glyph bit, mask[1] the row above it.
  typedef struct packed {
    logic [1:0]         mask;
    logic [COLOR_W-1:0] color;
  } line_entry_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    line_entry_t      data;
  } line_wr_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
  } line_rd_t;

  function automatic logic is_glyph(input logic [COLOR_W-1:0] rgb);
    return !((rgb[7:0] > WHITE_LEVEL) && (rgb[15:8] > WHITE_LEVEL) &&
             (rgb[23:16] > WHITE_LEVEL));
  endfunction

endpackage

`default_nettype wire

// ===== sv/gosc_line_ram.sv =====
`default_nettype none

// Line store: one write and one read port, registered read data.
module gosc_line_ram (
  input  wire logic                 clk,
  input  wire gosc_pkg::line_wr_t   wr,
  input  wire gosc_pkg::line_rd_t   rd,
  output gosc_pkg::line_entry_t     rd_data
);

  gosc_pkg::line_entry_t mem [gosc_pkg::LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/glyph_outline_shadow_compositor_top.sv =====
`default_nettype none
`include "glyph_outline_shadow_compositor_top_macros.svh"

// Glyph outline and drop shadow compositor. Pixels of a glyph arrive in raster
// order over a grid padded by two columns and two rows; each accepted pixel
// yields one screen write transaction for the position one row and one column
// back, carrying glyph colour, stroke colour or shadow colour, clipped to the
// screen. One pixel is taken every clock cycle while out_tready does not stall the
// output. Each result passes from the stage A registers and the line store read
// register through the output register, and a result held by out_tready stalls
// the input after one more pixel. The line store is written back when a pixel
// leaves the read stage, with forwarding covering a read of the column just
// written. The line store needs no clearing after reset: rows above the image
// read as background. Configuration must be written only while no pixel is in
// flight; the block itself does not enforce this.
module glyph_outline_shadow_compositor_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  // pixel input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [23:0] pixel_color
  // screen writes
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [0] write_enable, [11:1] screen_x,
                                       // [21:12] screen_y, [45:22] write_color,
                                       // [47:46] zero
  output logic             out_tlast   // frame_end
);

  localparam int COL_W = gosc_pkg::COL_W;
  localparam int ROW_W = gosc_pkg::ROW_W;
  localparam int SUM_W = gosc_pkg::SUM_W;
  localparam int CMP_W = gosc_pkg::CMP_W;
  localparam int CW    = gosc_pkg::COLOR_W;

  // Configuration registers
  logic [gosc_pkg::SIZE_W-1:0] glyph_width_r, glyph_height_r;
  logic [gosc_pkg::POS_W-1:0]  dest_x_r, dest_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r  <= gosc_pkg::SIZE_W'(1);
      glyph_height_r <= gosc_pkg::SIZE_W'(1);
      dest_x_r       <= '0;
      dest_y_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gosc_pkg::cfg_reg_t'(cfg_index))
        gosc_pkg::CFG_GLYPH_WIDTH:  glyph_width_r  <= cfg_data[gosc_pkg::SIZE_W-1:0];
        gosc_pkg::CFG_GLYPH_HEIGHT: glyph_height_r <= cfg_data[gosc_pkg::SIZE_W-1:0];
        gosc_pkg::CFG_DEST_X:       dest_x_r       <= cfg_data;
        gosc_pkg::CFG_DEST_Y:       dest_y_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes: zero reads as one, large values saturate.
  logic [CMP_W-1:0]            w_ext;
  logic [COL_W-1:0]            w_eff, w_last;
  logic [ROW_W-1:0]            h_eff, h_last;

  always_comb begin
    w_ext = CMP_W'(glyph_width_r);
    if (w_ext == '0) begin
      w_eff = COL_W'(1);
    end else if (w_ext > CMP_W'(gosc_pkg::MAX_GLYPH_WIDTH)) begin
      w_eff = COL_W'(gosc_pkg::MAX_GLYPH_WIDTH);
    end else begin
      w_eff = COL_W'(w_ext);
    end
    if (glyph_height_r == '0) begin
      h_eff = ROW_W'(1);
    end else if (glyph_height_r > gosc_pkg::SIZE_W'(gosc_pkg::HEIGHT_LIMIT)) begin
      h_eff = ROW_W'(gosc_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = ROW_W'(glyph_height_r);
    end
    w_last = w_eff + COL_W'(1);
    h_last = h_eff + ROW_W'(1);
  end

  // Stage A: grid position, glyph test, line store read
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt, c_a;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt, r_a;
  logic             in_accept, g_a, a_last;
  logic [SUM_W-1:0] px_a, py_a;

  logic             s1_valid_r, s1_adv;
  logic [COL_W-1:0] s1_c_r;
  logic [CW-1:0]    s1_pix_r;
  logic             s1_g_r, s1_pos_ok_r, s1_inside_r, s1_up1_ok_r, s1_up2_ok_r;
  logic             s1_last_r;
  logic [SUM_W-1:0] s1_px_r, s1_py_r;

  assign in_tready = !s1_valid_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    c_a    = (col_cnt_r > w_last) ? w_last : col_cnt_r;
    r_a    = (row_cnt_r > h_last) ? h_last : row_cnt_r;
    g_a    = (c_a < w_eff) && (r_a < h_eff) && gosc_pkg::is_glyph(in_tdata);
    a_last = (c_a == w_last) && (r_a == h_last);
    px_a   = SUM_W'($signed(dest_x_r)) + SUM_W'(COL_W'(c_a - COL_W'(1)));
    py_a   = SUM_W'($signed(dest_y_r)) + SUM_W'(ROW_W'(r_a - ROW_W'(1)));
    if (c_a >= w_last) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (r_a >= h_last) ? '0 : r_a + ROW_W'(1);
    end else begin
      col_cnt_nxt = c_a + COL_W'(1);
      row_cnt_nxt = r_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_accept) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_c_r      <= c_a;
      s1_pix_r    <= in_tdata;
      s1_g_r      <= g_a;
      s1_pos_ok_r <= (c_a != '0) && (r_a != '0);
      s1_inside_r <= (c_a <= w_eff) && (r_a <= h_eff);
      s1_up1_ok_r <= (r_a >= ROW_W'(1));
      s1_up2_ok_r <= (r_a >= ROW_W'(2));
      s1_last_r   <= a_last;
      s1_px_r     <= px_a;
      s1_py_r     <= py_a;
    end
  end

  // Line store
  gosc_pkg::line_wr_t    ram_wr;
  gosc_pkg::line_rd_t    ram_rd;
  gosc_pkg::line_entry_t ram_rdata;

  assign ram_rd.en   = in_accept;
  assign ram_rd.addr = c_a;

  gosc_line_ram u_line_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (ram_rdata)
  );

  // The read issued in the same cycle as a write-back to that column sees the
  // old entry, so the last write is held for forwarding.
  logic                  fwd_valid_r;
  logic [COL_W-1:0]      fwd_addr_r;
  gosc_pkg::line_entry_t fwd_data_r;

  // Stage B: window update, classification, clipping
  gosc_pkg::line_entry_t line_q;
  logic [8:0]            win_r, win_nxt;
  logic [CW-1:0]         center_r;
  logic                  up1, up2, hit, onscreen;
  logic [CW-1:0]         color_b;

  always_comb begin
    line_q  = (fwd_valid_r && (fwd_addr_r == s1_c_r)) ? fwd_data_r : ram_rdata;
    up1     = s1_up1_ok_r && line_q.mask[0];
    up2     = s1_up2_ok_r && line_q.mask[1];
    win_nxt = {win_r[7:6], up2, win_r[4:3], up1, win_r[1:0], s1_g_r};
    hit     = 1'b0;
    color_b = '0;
    if (s1_pos_ok_r) begin
      if (s1_inside_r) begin
        if (win_nxt[4]) begin
          hit     = 1'b1;
          color_b = center_r;
        end else if ((win_nxt & 9'h1EF) != '0) begin
          hit     = 1'b1;
          color_b = gosc_pkg::STROKE_RGB;
        end
      end else if (win_nxt[8]) begin
        hit     = 1'b1;
        color_b = gosc_pkg::SHADOW_RGB;
      end
    end
    onscreen = !s1_px_r[SUM_W-1] && (s1_px_r < SUM_W'(gosc_pkg::SCREEN_WIDTH)) &&
               !s1_py_r[SUM_W-1] && (s1_py_r < SUM_W'(gosc_pkg::SCREEN_HEIGHT));
  end

  assign ram_wr.en         = s1_adv;
  assign ram_wr.addr       = s1_c_r;
  assign ram_wr.data.mask  = {up1, s1_g_r};
  assign ram_wr.data.color = s1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      center_r    <= '0;
      fwd_valid_r <= 1'b0;
    end else if (s1_adv) begin
      win_r       <= win_nxt;
      center_r    <= line_q.color;
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      fwd_addr_r <= s1_c_r;
      fwd_data_r <= ram_wr.data;
    end
  end

  // Output register
  logic                          out_valid_r;
  logic                          out_we_r, out_last_r;
  logic [gosc_pkg::SX_W-1:0]     out_sx_r;
  logic [gosc_pkg::SY_W-1:0]     out_sy_r;
  logic [CW-1:0]                 out_color_r;

  assign s1_adv = s1_valid_r && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_we_r    <= hit && onscreen;
      out_sx_r    <= (hit && onscreen) ? s1_px_r[gosc_pkg::SX_W-1:0] : '0;
      out_sy_r    <= (hit && onscreen) ? s1_py_r[gosc_pkg::SY_W-1:0] : '0;
      out_color_r <= (hit && onscreen) ? color_b : '0;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_color_r, out_sy_r, out_sx_r, out_we_r};
  assign out_tlast  = out_last_r;

  // The last grid position of a glyph returns the raster to its origin.
  `GOSC_ASSERT_NEXT(a_frame_wrap, clk, rst_n, in_accept && a_last, (col_cnt_r == '0) && (row_cnt_r == '0))
  // A stalled pixel keeps its column and colour until it moves on.
  `GOSC_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_c_r) && $stable(s1_pix_r))
  // Every write-back is captured for forwarding to the next read.
  `GOSC_ASSERT_NEXT(a_fwd_track, clk, rst_n, s1_adv, fwd_valid_r && (fwd_addr_r == $past(s1_c_r)))

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 200;

  typedef enum logic [1:0] {
    STIM_PIXEL,
    STIM_CFG,
    STIM_DRAIN
  } stim_kind_t;

  typedef struct {
    stim_kind_t         kind;
    gosc_pkg::cfg_reg_t index;
    logic [11:0]        value;
    logic [23:0]        pixel;
  } stim_entry_t;

  typedef struct packed {
    logic        we;
    logic [10:0] sx;
    logic [9:0]  sy;
    logic [23:0] color;
    logic        last;
  } screen_write_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;

  stim_entry_t   stim_q[$];
  screen_write_t screen_writes_q[$];
  int            errors = 0;
  int            cycle_cnt = 0;
  int            settle_cnt = 0;
  logic          calm;

  // Generator's view of the size registers, used to size whole frames.
  int stim_w = 1;
  int stim_h = 1;
  int item_cnt = 0;

  // Predictor state.
  logic [8:0]         glyph_w_q = 9'd1;
  logic [8:0]         glyph_h_q = 9'd1;
  logic signed [11:0] dest_x_q = '0;
  logic signed [11:0] dest_y_q = '0;
  int                 col_cnt = 0;
  int                 row_cnt = 0;
  logic [1:0]         ink_rows [0:gosc_pkg::LINE_DEPTH-1];
  logic [23:0]        hue_rows [0:gosc_pkg::LINE_DEPTH-1];
  logic [8:0]         ink_window = '0;
  logic [23:0]        hue_delay [0:1];

  glyph_outline_shadow_compositor_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  assign calm = (cycle_cnt >= 400) && (cycle_cnt < 1000);

  function automatic int eff_size(int v, int limit);
    if (v == 0) return 1;
    return (v > limit) ? limit : v;
  endfunction

  function automatic logic pixel_is_ink(logic [23:0] rgb);
    return !((rgb[7:0] > gosc_pkg::WHITE_LEVEL) && (rgb[15:8] > gosc_pkg::WHITE_LEVEL) &&
             (rgb[23:16] > gosc_pkg::WHITE_LEVEL));
  endfunction

  task automatic apply_register(gosc_pkg::cfg_reg_t idx, logic [11:0] val);
    case (idx)
      gosc_pkg::CFG_GLYPH_WIDTH:  glyph_w_q = val[8:0];
      gosc_pkg::CFG_GLYPH_HEIGHT: glyph_h_q = val[8:0];
      gosc_pkg::CFG_DEST_X:       dest_x_q = val;
      gosc_pkg::CFG_DEST_Y:       dest_y_q = val;
      default: ;
    endcase
  endtask

  // Advances the predictor by one grid position and queues the screen write.
  task automatic predict_write(logic [23:0] pix);
    int            w, h, c, r, col_x, row_y, px, py;
    logic          g, up1, up2, hit;
    logic [1:0]    stored;
    logic [23:0]   center;
    screen_write_t wr;
    w = eff_size(glyph_w_q, gosc_pkg::MAX_GLYPH_WIDTH);
    h = eff_size(glyph_h_q, gosc_pkg::HEIGHT_LIMIT);
    c = (col_cnt > w + 1) ? w + 1 : col_cnt;
    r = (row_cnt > h + 1) ? h + 1 : row_cnt;
    g = (c < w) && (r < h) && pixel_is_ink(pix);
    stored = ink_rows[c];
    up1 = (r >= 1) ? stored[0] : 1'b0;
    up2 = (r >= 2) ? stored[1] : 1'b0;
    ink_window = {ink_window[7:6], up2, ink_window[4:3], up1, ink_window[1:0], g};
    ink_rows[c] = {up1, g};
    hue_delay[1] = hue_delay[0];
    hue_delay[0] = hue_rows[c];
    center = hue_delay[1];
    hue_rows[c] = pix;

    wr = '0;
    if (c >= 1 && r >= 1) begin
      col_x = c - 1;
      row_y = r - 1;
      hit = 1'b0;
      if (col_x < w && row_y < h) begin
        if (ink_window[4]) begin
          hit = 1'b1;
          wr.color = center;
        end else if ((ink_window & 9'h1EF) != 0) begin
          hit = 1'b1;
          wr.color = gosc_pkg::STROKE_RGB;
        end
      end else if (ink_window[8]) begin
        hit = 1'b1;
        wr.color = gosc_pkg::SHADOW_RGB;
      end
      if (hit) begin
        px = dest_x_q;
        py = dest_y_q;
        px += col_x;
        py += row_y;
        if (px >= 0 && px < gosc_pkg::SCREEN_WIDTH && py >= 0 &&
            py < gosc_pkg::SCREEN_HEIGHT) begin
          wr.we = 1'b1;
          wr.sx = px[10:0];
          wr.sy = py[9:0];
        end else begin
          wr.color = '0;
        end
      end
    end
    wr.last = (c == w + 1) && (r == h + 1);
    screen_writes_q.push_back(wr);

    if (c >= w + 1) begin
      col_cnt = 0;
      row_cnt = (r >= h + 1) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  // Stimulus helpers.
  task automatic push_pixel(logic [23:0] pix);
    stim_entry_t e;
    e.kind = STIM_PIXEL;
    e.index = gosc_pkg::CFG_GLYPH_WIDTH;
    e.value = '0;
    e.pixel = pix;
    stim_q.push_back(e);
    item_cnt++;
  endtask

  task automatic set_reg(gosc_pkg::cfg_reg_t idx, logic [11:0] val);
    stim_entry_t e;
    e.kind = STIM_CFG;
    e.index = idx;
    e.value = val;
    e.pixel = '0;
    stim_q.push_back(e);
    if (idx == gosc_pkg::CFG_GLYPH_WIDTH) stim_w = val[8:0];
    if (idx == gosc_pkg::CFG_GLYPH_HEIGHT) stim_h = val[8:0];
  endtask

  // Holds the sender until every queued screen write has come back.
  task automatic push_drain();
    stim_entry_t e;
    e.kind = STIM_DRAIN;
    e.index = gosc_pkg::CFG_GLYPH_WIDTH;
    e.value = '0;
    e.pixel = '0;
    stim_q.push_back(e);
  endtask

  function automatic logic [23:0] make_pixel(int ink_pct);
    logic [23:0] p;
    int          sel;
    p = $urandom;
    if ($urandom_range(0, 99) < 10) return p;
    if ($urandom_range(0, 99) < ink_pct) begin
      if (!pixel_is_ink(p)) begin
        sel = $urandom_range(0, 2);
        p[8*sel +: 8] = 8'($urandom_range(0, 245));
      end
    end else begin
      p = {8'($urandom_range(246, 255)), 8'($urandom_range(246, 255)),
           8'($urandom_range(246, 255))};
    end
    return p;
  endfunction

  task automatic push_frame(int ink_pct);
    repeat ((eff_size(stim_w, gosc_pkg::MAX_GLYPH_WIDTH) + 2) *
            (eff_size(stim_h, gosc_pkg::HEIGHT_LIMIT) + 2))
      push_pixel(make_pixel(ink_pct));
  endtask

  function automatic logic [8:0] pick_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return 9'd0;
    if (pick < 15) return 9'($urandom_range(9, 16));
    return 9'($urandom_range(1, 8));
  endfunction

  function automatic logic [11:0] pick_dest(int edge_pos);
    case ($urandom_range(0, 3))
      0: return 12'($urandom);
      1: return 12'($urandom_range(0, 8) - 4);
      2: return 12'(edge_pos - 4 + $urandom_range(0, 8));
      default: return 12'($urandom_range(0, 100));
    endcase
  endfunction

  // Driver: walks the stimulus queue, one handshake at a time.
  always @(posedge clk) begin : drive_proc
    stim_entry_t head;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
      settle_cnt <= 0;
    end else begin
      if (in_tvalid && in_tready) predict_write(in_tdata);
      if (cfg_valid && cfg_ready) apply_register(gosc_pkg::cfg_reg_t'(cfg_index), cfg_data);
      if ((!in_tvalid || in_tready) && (!cfg_valid || cfg_ready)) begin
        if (stim_q.size() == 0) begin
          in_tvalid <= 1'b0;
          cfg_valid <= 1'b0;
        end else begin
          head = stim_q[0];
          case (head.kind)
            STIM_PIXEL: begin
              cfg_valid <= 1'b0;
              if (!calm && $urandom_range(0, 99) < 10) begin
                in_tvalid <= 1'b0;
              end else begin
                in_tvalid <= 1'b1;
                in_tdata <= head.pixel;
                stim_q.delete(0);
              end
            end
            STIM_CFG: begin
              in_tvalid <= 1'b0;
              cfg_valid <= 1'b1;
              cfg_index <= head.index;
              cfg_data <= head.value;
              stim_q.delete(0);
            end
            default: begin
              in_tvalid <= 1'b0;
              cfg_valid <= 1'b0;
              if (screen_writes_q.size() != 0) begin
                settle_cnt <= 0;
              end else if (settle_cnt >= SETTLE_CYCLES) begin
                settle_cnt <= 0;
                stim_q.delete(0);
              end else begin
                settle_cnt <= settle_cnt + 1;
              end
            end
          endcase
        end
      end
    end
  end

  // Monitor: every screen write transaction is matched against the oldest prediction.
  always @(posedge clk) begin : watch_proc
    screen_write_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (screen_writes_q.size() == 0) begin
          $error("screen write with no expectation: tdata %h tlast %b", out_tdata, out_tlast);
          errors++;
        end else begin
          want = screen_writes_q.pop_front();
          check_field("write_enable", want.we, out_tdata[0]);
          check_field("screen_x", want.sx, out_tdata[11:1]);
          check_field("screen_y", want.sy, out_tdata[21:12]);
          check_field("write_color", want.color, out_tdata[45:22]);
          check_field("pad", 0, out_tdata[47:46]);
          check_field("frame_end", want.last, out_tlast);
        end
      end
      out_tready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int ink;
    for (int i = 0; i < gosc_pkg::LINE_DEPTH; i++) begin
      ink_rows[i] = '0;
      hue_rows[i] = '0;
    end
    hue_delay[0] = '0;
    hue_delay[1] = '0;

    // Reset sizes: a lone dark pixel gets a stroke ring and a shadow corner.
    push_pixel(24'h000000);
    repeat (8) push_pixel(make_pixel(50));

    // Threshold: 245 in every channel is still ink, 246 is background.
    // Upper data bits above the size field must be dropped.
    push_drain();
    set_reg(gosc_pkg::CFG_GLYPH_WIDTH, 12'hE02);
    set_reg(gosc_pkg::CFG_GLYPH_HEIGHT, 12'h001);
    set_reg(gosc_pkg::CFG_DEST_X, 12'd0);
    set_reg(gosc_pkg::CFG_DEST_Y, 12'd0);
    push_pixel(24'hF5F5F5);
    push_pixel(24'hF6F6F6);
    repeat (10) push_pixel(make_pixel(50));

    // Shrink the glyph mid-frame; the counters stay within the new bounds.
    push_drain();
    set_reg(gosc_pkg::CFG_GLYPH_WIDTH, 12'd4);
    set_reg(gosc_pkg::CFG_GLYPH_HEIGHT, 12'd3);
    repeat (15) push_pixel(make_pixel(60));
    push_drain();
    set_reg(gosc_pkg::CFG_GLYPH_WIDTH, 12'd2);
    set_reg(gosc_pkg::CFG_GLYPH_HEIGHT, 12'd2);
    repeat (5) push_pixel(make_pixel(60));

    // Clipping at each screen edge and at the position extremes.
    push_drain();
    set_reg(gosc_pkg::CFG_GLYPH_WIDTH, 12'd4);
    set_reg(gosc_pkg::CFG_GLYPH_HEIGHT, 12'd3);
    set_reg(gosc_pkg::CFG_DEST_X, 12'd1278);
    set_reg(gosc_pkg::CFG_DEST_Y, 12'd718);
    push_frame(50);
    push_drain();
    set_reg(gosc_pkg::CFG_DEST_X, 12'(-2));
    set_reg(gosc_pkg::CFG_DEST_Y, 12'(-1));
    push_frame(50);
    push_drain();
    set_reg(gosc_pkg::CFG_DEST_X, 12'h7FF);
    set_reg(gosc_pkg::CFG_DEST_Y, 12'h800);
    push_frame(50);
    push_drain();
    set_reg(gosc_pkg::CFG_DEST_X, 12'h800);
    set_reg(gosc_pkg::CFG_DEST_Y, 12'h7FF);
    push_frame(50);

    // Largest sizes, and sizes that saturate or read as one.
    push_drain();
    set_reg(gosc_pkg::CFG_GLYPH_WIDTH, 12'd400);
    set_reg(gosc_pkg::CFG_GLYPH_HEIGHT, 12'd0);
    set_reg(gosc_pkg::CFG_DEST_X, 12'd1100);
    set_reg(gosc_pkg::CFG_DEST_Y, 12'd719);
    push_frame(50);

    // Random frames, often back to back, with registers changed between groups.
    item_cnt = 0;
    while (item_cnt < RANDOM_ITEMS) begin
      push_drain();
      if ($urandom_range(0, 1)) begin
        set_reg(gosc_pkg::CFG_GLYPH_WIDTH, {3'($urandom), pick_size()});
      end
      if ($urandom_range(0, 1)) begin
        set_reg(gosc_pkg::CFG_GLYPH_HEIGHT, {3'($urandom), pick_size()});
      end
      if ($urandom_range(0, 1)) begin
        set_reg(gosc_pkg::CFG_DEST_X, pick_dest(gosc_pkg::SCREEN_WIDTH));
      end
      if ($urandom_range(0, 1)) begin
        set_reg(gosc_pkg::CFG_DEST_Y, pick_dest(gosc_pkg::SCREEN_HEIGHT));
      end
      repeat ($urandom_range(1, 3)) begin
        ink = 10 + 40 * $urandom_range(0, 2);
        push_frame(ink);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_tvalid || cfg_valid || screen_writes_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && screen_writes_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
